FILE: rtl/pasd_pkg.sv
// Shared types, constants and pattern tables for the prologue arg-save detector.
package pasd_pkg;

  localparam int REG_ARGS         = 6;
  localparam int MAX_PROLOG_BYTES = 64;
  localparam int TABLE_LEN        = 6;

  // rsp-to-rbp moves, 3 bytes, little-endian
  localparam logic [23:0] MOVE_A = 24'he58948;
  localparam logic [23:0] MOVE_B = 24'hec8b48;

  localparam logic [7:0] PUSH_RBP = 8'h55;
  localparam logic [7:0] PUSH_ALT = 8'hcc;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_TRAD   = 2'd1;
  localparam logic [1:0] KIND_STRUCT = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } pasd_result_t;

  function automatic logic [31:0] move_code(input logic [2:0] idx);
    logic [31:0] code;
    case (idx)
      3'd0:    code = 32'hf87d8948;
      3'd1:    code = 32'hf0758948;
      3'd2:    code = 32'he8558948;
      3'd3:    code = 32'he04d8948;
      3'd4:    code = 32'hd845894c;
      3'd5:    code = 32'hd04d894c;
      default: code = 32'h0;
    endcase
    return code;
  endfunction

  function automatic logic [15:0] push_code(input logic [2:0] idx);
    logic [15:0] code;
    case (idx)
      3'd0:    code = 16'h0057;
      3'd1:    code = 16'h0056;
      3'd2:    code = 16'h0052;
      3'd3:    code = 16'h0051;
      3'd4:    code = 16'h5041;
      3'd5:    code = 16'h5141;
      default: code = 16'h0;
    endcase
    return code;
  endfunction

  function automatic logic move_hit(input logic [3:0] idx, input logic [31:0] value);
    logic ok;
    ok = (idx < 4'(TABLE_LEN)) && (idx < 4'(REG_ARGS));
    return ok && (move_code(idx[2:0]) == value);
  endfunction

  function automatic logic push_hit(input logic [2:0] idx, input logic [15:0] value);
    logic ok;
    ok = (idx < 3'(TABLE_LEN)) && (idx < 3'(REG_ARGS));
    return ok && (push_code(idx) == value);
  endfunction

endpackage

FILE: rtl/pasd_core.sv
// Per-byte state update: frame-pointer test, three save matchers, classification.
module pasd_core
  import pasd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   code_byte,
  input  logic         first_byte,
  input  logic         last_byte,
  input  logic [7:0]   arg_count,
  input  logic         struct_return,
  output pasd_result_t result
);

  logic [31:0] window_r, window_nxt, window_b;
  logic [7:0]  pos_r, pos_nxt, pos_b;
  logic [2:0]  limit_r, limit_nxt, limit_b;
  logic        start_r, start_nxt, start_b;
  logic        push_seen_r, push_seen_nxt, push_seen_b;
  logic        frame_r, frame_nxt, frame_b;
  logic [2:0]  fidx_r, fidx_nxt, fidx_b;
  logic [3:0]  ridx_r, ridx_nxt, ridx_b;
  logic [2:0]  pidx_r, pidx_nxt, pidx_b;
  logic [1:0]  skip0_r, skip0_nxt, skip0_b;
  logic [1:0]  skip1_r, skip1_nxt, skip1_b;
  logic [1:0]  skip2_r, skip2_nxt, skip2_b;
  logic [2:0]  done_r, done_nxt, done_b;

  logic [8:0]  eff_sum;
  logic [2:0]  eff;
  logic [3:0]  split;
  logic [23:0] w3;
  logic [1:0]  kind;

  // first byte starts from a clean slate with the sampled counts
  always_comb begin
    eff_sum = {1'b0, arg_count} + 9'(struct_return);
    eff     = (eff_sum > 9'(REG_ARGS)) ? 3'(REG_ARGS) : eff_sum[2:0];
    if (first_byte) begin
      window_b    = '0;
      pos_b       = '0;
      limit_b     = eff;
      start_b     = struct_return;
      push_seen_b = 1'b0;
      frame_b     = 1'b0;
      fidx_b      = '0;
      ridx_b      = (eff != 3'd0) ? {1'b0, eff - 3'd1} : 4'd0;
      pidx_b      = {2'b0, struct_return};
      skip0_b     = '0;
      skip1_b     = '0;
      skip2_b     = '0;
      done_b      = '0;
    end else begin
      window_b    = window_r;
      pos_b       = pos_r;
      limit_b     = limit_r;
      start_b     = start_r;
      push_seen_b = push_seen_r;
      frame_b     = frame_r;
      fidx_b      = fidx_r;
      ridx_b      = ridx_r;
      pidx_b      = pidx_r;
      skip0_b     = skip0_r;
      skip1_b     = skip1_r;
      skip2_b     = skip2_r;
      done_b      = done_r;
    end
  end

  always_comb begin
    window_nxt    = window_b;
    limit_nxt     = limit_b;
    start_nxt     = start_b;
    push_seen_nxt = push_seen_b;
    frame_nxt     = frame_b;
    fidx_nxt      = fidx_b;
    ridx_nxt      = ridx_b;
    pidx_nxt      = pidx_b;
    skip0_nxt     = skip0_b;
    skip1_nxt     = skip1_b;
    skip2_nxt     = skip2_b;
    done_nxt      = done_b;
    pos_nxt       = (pos_b != 8'hff) ? pos_b + 8'd1 : 8'hff;
    split         = 4'd8 - {3'b0, start_b};
    w3            = '0;

    if (pos_b < 8'(MAX_PROLOG_BYTES)) begin
      window_nxt = {code_byte, window_b[31:8]};
      w3         = window_nxt[31:8];

      if (!push_seen_b) begin
        if (code_byte == PUSH_RBP || code_byte == PUSH_ALT)
          push_seen_nxt = 1'b1;
      end else if (pos_b >= 8'd2) begin
        if (w3 == MOVE_A || w3 == MOVE_B)
          frame_nxt = 1'b1;
      end

      // forward order
      if (pos_b >= 8'd7 && !done_b[0]) begin
        if (skip0_b != 2'd0) begin
          skip0_nxt = skip0_b - 2'd1;
        end else if (move_hit({1'b0, fidx_b}, window_nxt)) begin
          skip0_nxt = 2'd3;
          fidx_nxt  = fidx_b + 3'd1;
          if (fidx_nxt >= limit_b)
            done_nxt[0] = 1'b1;
        end
      end

      // reverse order
      if (pos_b >= 8'd7 && !done_b[1]) begin
        if (skip1_b != 2'd0) begin
          skip1_nxt = skip1_b - 2'd1;
        end else if (move_hit(ridx_b, window_nxt)) begin
          skip1_nxt = 2'd3;
          if (ridx_b <= {3'b0, start_b})
            done_nxt[1] = 1'b1;
          else
            ridx_nxt = ridx_b - 4'd1;
        end
      end

      // pushes: single bytes early, 2-byte words after the split
      if (!done_b[2]) begin
        if (pos_b >= 8'd4 && pos_b < {4'b0, split}) begin
          if (!last_byte && push_hit(pidx_b, {8'h0, code_byte})) begin
            pidx_nxt = pidx_b + 3'd1;
            if (pidx_nxt >= limit_b)
              done_nxt[2] = 1'b1;
          end
        end else if (pos_b > {4'b0, split}) begin
          if (skip2_b != 2'd0) begin
            skip2_nxt = skip2_b - 2'd1;
          end else if (push_hit(pidx_b, window_nxt[31:16])) begin
            skip2_nxt = 2'd1;
            pidx_nxt  = pidx_b + 3'd1;
            if (pidx_nxt >= limit_b)
              done_nxt[2] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    kind = KIND_NONE;
    if (limit_nxt != 3'd0 && frame_nxt) begin
      if (done_nxt[0])
        kind = start_nxt ? KIND_STRUCT : KIND_TRAD;
      else if (done_nxt[1] || done_nxt[2])
        kind = KIND_TRAD;
    end
    result.valid = step && last_byte;
    result.kind  = kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      window_r    <= '0;
      pos_r       <= '0;
      limit_r     <= '0;
      start_r     <= 1'b0;
      push_seen_r <= 1'b0;
      frame_r     <= 1'b0;
      fidx_r      <= '0;
      ridx_r      <= '0;
      pidx_r      <= '0;
      skip0_r     <= '0;
      skip1_r     <= '0;
      skip2_r     <= '0;
      done_r      <= '0;
    end else if (step) begin
      window_r    <= window_nxt;
      pos_r       <= pos_nxt;
      limit_r     <= limit_nxt;
      start_r     <= start_nxt;
      push_seen_r <= push_seen_nxt;
      frame_r     <= frame_nxt;
      fidx_r      <= fidx_nxt;
      ridx_r      <= ridx_nxt;
      pidx_r      <= pidx_nxt;
      skip0_r     <= skip0_nxt;
      skip1_r     <= skip1_nxt;
      skip2_r     <= skip2_nxt;
      done_r      <= done_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> pos_r == 8'd0 && done_r == 3'd0 && limit_r == 3'd0)
    else $error("state not cleared after final byte");

  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    limit_r <= 3'(REG_ARGS))
    else $error("effective count above register arg count");

  a_struct_kind: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid && result.kind == KIND_STRUCT |-> start_nxt && done_nxt[0])
    else $error("struct kind without struct return and forward match");
`endif

endmodule

FILE: rtl/prolog_arg_save_detector.sv
// Top level: stream handshake, output register and the per-byte detector core.
//
//  channel | ports                                   | word
//  in      | in_tvalid/in_tready/in_tdata/in_tuser/  | one prologue byte plus counts
//          | in_tlast                                |
//  out     | out_tvalid/out_tready/out_tdata         | arg_kind, one per prologue
//
// One byte per cycle while in_tready is high; the state update for a byte is one combinational pass
// between the core's state registers and the output register.
// The result appears on out_tdata the cycle after the last byte is taken.
// in_tready drops only while a result sits in the output register unaccepted.
// rst_n is synchronous; reset clears all detector state and the output valid.
module prolog_arg_save_detector
  import pasd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] code_byte, [15:8] arg_count, [16] struct_return
  input  logic [0:0]  in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] arg_kind
);

  logic         out_valid_r;
  logic [1:0]   out_kind_r;
  logic         in_accept;
  pasd_result_t res;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  pasd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_accept),
    .code_byte     (in_tdata[7:0]),
    .first_byte    (in_tuser[0]),
    .last_byte     (in_tlast),
    .arg_count     (in_tdata[15:8]),
    .struct_return (in_tdata[16]),
    .result        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid)
      out_kind_r <= res.kind;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_kind_r};

`ifndef ASSERT_OFF
  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast |=> out_valid_r)
    else $error("final byte produced no result word");

  a_no_result_midstream: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_tlast && !(out_valid_r && !out_tready) |=> !out_valid_r)
    else $error("result word without final byte");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_kind_r != 2'd3)
    else $error("illegal arg kind");
`endif

endmodule

FILE: sim/prolog_arg_save_detector_tb.sv
// Testbench for the prologue arg-save detector: byte-stream stimulus, predictor, scoreboard.
module prolog_arg_save_detector_tb
  import pasd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int MAX_PRINTS = 100;

  typedef enum int {M_FWD, M_REV, M_PUSH} matcher_e;
  typedef enum int {SHAPE_FORWARD, SHAPE_REVERSE, SHAPE_PUSHES, SHAPE_MIXED, SHAPE_NOISE} shape_e;
  typedef enum int {START_MARKED, START_MISSING, START_REPEATED} start_e;

  // save moves of rdi..r9 and the matching pushes, little-endian
  logic [31:0] save_move [TABLE_LEN] = '{32'hf87d8948, 32'hf0758948, 32'he8558948,
                                         32'he04d8948, 32'hd845894c, 32'hd04d894c};
  logic [15:0] push_op [TABLE_LEN] = '{16'h0057, 16'h0056, 16'h0052,
                                       16'h0051, 16'h5041, 16'h5141};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] code_byte, [15:8] arg_count, [16] struct_return
  logic [0:0]  in_tuser = '0;   // [0] first_byte
  logic        in_tlast = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [1:0] arg_kind

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int cycle_count = 0;
  int mismatches = 0;

  logic [1:0] kind_q [$];
  logic [7:0] prolog_bytes [$];

  // predictor state
  logic [31:0] win = '0;
  int unsigned pos = 0, lim = 0, soff = 0;
  int unsigned fwd_idx = 0, rev_idx = 0, push_idx = 0;
  int unsigned skip_cnt [3] = '{0, 0, 0};
  bit push_seen = 0, frame_ok = 0;
  bit [2:0] done_mask = '0;

  prolog_arg_save_detector dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit save_hit(int unsigned idx, logic [31:0] value);
    if (idx >= TABLE_LEN || idx >= REG_ARGS) return 0;
    return save_move[idx] == value;
  endfunction

  function automatic bit push_hit(int unsigned idx, logic [15:0] value);
    if (idx >= TABLE_LEN || idx >= REG_ARGS) return 0;
    return push_op[idx] == value;
  endfunction

  task automatic clear_detector();
    win = '0; pos = 0; lim = 0; soff = 0;
    fwd_idx = 0; rev_idx = 0; push_idx = 0;
    skip_cnt = '{0, 0, 0};
    push_seen = 0; frame_ok = 0; done_mask = '0;
  endtask

  // one byte through the detector; emits is set on the final byte
  task automatic advance_detector(input logic [7:0] b, input bit first, input bit last,
                                  input logic [7:0] argc, input bit sret,
                                  output bit emits, output logic [1:0] kind);
    int unsigned q, eff, split;
    emits = 0;
    kind = KIND_NONE;
    if (first) begin
      clear_detector();
      eff = argc + sret;
      if (eff > REG_ARGS) eff = REG_ARGS;
      lim = eff;
      soff = sret;
      rev_idx = (eff > 0) ? eff - 1 : 0;
      push_idx = sret;
    end
    q = pos;
    pos = (q < 255) ? q + 1 : 255;
    if (q < MAX_PROLOG_BYTES) begin
      split = 8 - soff;
      win = {b, win[31:8]};
      if (!push_seen) begin
        if (b == PUSH_RBP || b == PUSH_ALT) push_seen = 1;
      end else if (q >= 2) begin
        if (win[31:8] == MOVE_A || win[31:8] == MOVE_B) frame_ok = 1;
      end
      if (q >= 7 && !done_mask[M_FWD]) begin
        if (skip_cnt[M_FWD] != 0) begin
          skip_cnt[M_FWD]--;
        end else if (save_hit(fwd_idx, win)) begin
          skip_cnt[M_FWD] = 3;
          fwd_idx++;
          if (fwd_idx >= lim) done_mask[M_FWD] = 1;
        end
      end
      if (q >= 7 && !done_mask[M_REV]) begin
        if (skip_cnt[M_REV] != 0) begin
          skip_cnt[M_REV]--;
        end else if (save_hit(rev_idx, win)) begin
          skip_cnt[M_REV] = 3;
          if (rev_idx <= soff) done_mask[M_REV] = 1;
          else rev_idx--;
        end
      end
      if (!done_mask[M_PUSH]) begin
        if (q >= 4 && q < split) begin
          // single-byte pushes; never checked on the final byte
          if (!last && push_hit(push_idx, {8'h00, b})) begin
            push_idx++;
            if (push_idx >= lim) done_mask[M_PUSH] = 1;
          end
        end else if (q >= split + 1) begin
          if (skip_cnt[M_PUSH] != 0) begin
            skip_cnt[M_PUSH]--;
          end else if (push_hit(push_idx, win[31:16])) begin
            skip_cnt[M_PUSH] = 1;
            push_idx++;
            if (push_idx >= lim) done_mask[M_PUSH] = 1;
          end
        end
      end
    end
    if (last) begin
      emits = 1;
      if (lim != 0 && frame_ok) begin
        if (done_mask[M_FWD]) kind = soff ? KIND_STRUCT : KIND_TRAD;
        else if (done_mask[M_REV] || done_mask[M_PUSH]) kind = KIND_TRAD;
      end
      clear_detector();
    end
  endtask

  task automatic report_mismatch(string what, logic [1:0] got, logic [1:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t mismatch: %s, got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // input words feed the predictor, output words are checked in order
  always @(posedge clk) begin : scoreboard
    bit emits;
    logic [1:0] kind;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        advance_detector(in_tdata[7:0], in_tuser[0], in_tlast, in_tdata[15:8], in_tdata[16],
                         emits, kind);
        if (emits) kind_q.push_back(kind);
      end
      if (out_tvalid && out_tready) begin
        if (kind_q.size() == 0) begin
          report_mismatch("unexpected arg_kind word", out_tdata[1:0], KIND_NONE);
        end else begin
          kind = kind_q.pop_front();
          if (out_tdata[1:0] !== kind) report_mismatch("arg_kind", out_tdata[1:0], kind);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // a toggle of hold_req starts a long receiver hold-off
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_left <= HOLDOFF_CYCLES;
      hold_ack <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_word(logic [7:0] b, bit first, bit last, logic [7:0] argc, bit sret);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, sret, argc, b};
    in_tuser <= first;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // counts on words other than a first are junk the block must ignore
  task automatic send_prologue(logic [7:0] argc, bit sret, start_e start);
    int restart;
    bit first;
    restart = $urandom_range(1, (prolog_bytes.size() > 1) ? prolog_bytes.size() - 1 : 1);
    for (int i = 0; i < prolog_bytes.size(); i++) begin
      first = (start == START_MARKED && i == 0) ||
              (start == START_REPEATED && (i == 0 || i == restart));
      if (first)
        send_word(prolog_bytes[i], 1'b1, i == prolog_bytes.size() - 1, argc, sret);
      else
        send_word(prolog_bytes[i], 1'b0, i == prolog_bytes.size() - 1,
                  8'($urandom), 1'($urandom));
    end
  endtask

  task automatic add_code(logic [31:0] code, int n);
    for (int k = 0; k < n; k++) prolog_bytes.push_back(code[8*k +: 8]);
  endtask

  task automatic add_push(int idx);
    add_code({16'h0, push_op[idx]}, (push_op[idx] > 16'h00ff) ? 2 : 1);
  endtask

  function automatic logic [7:0] pick_arg_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(0, 7));
    if (r < 88) return 8'($urandom_range(0, 255));
    return (r < 94) ? 8'hff : 8'h00;
  endfunction

  function automatic int eff_count(logic [7:0] argc, bit sret);
    int eff;
    eff = argc + sret;
    return (eff > REG_ARGS) ? REG_ARGS : eff;
  endfunction

  task automatic build_prologue(shape_e shape, int eff, bit sret);
    int r;
    prolog_bytes.delete();
    r = $urandom_range(99);
    if (r < 90) begin
      prolog_bytes.push_back($urandom_range(1) ? PUSH_RBP : PUSH_ALT);
      if (r >= 80) prolog_bytes.push_back(8'($urandom));
      add_code($urandom_range(1) ? {8'h0, MOVE_A} : {8'h0, MOVE_B}, 3);
    end else begin
      repeat ($urandom_range(0, 4)) prolog_bytes.push_back(8'($urandom));
    end
    case (shape)
      SHAPE_FORWARD: for (int i = 0; i < eff; i++) add_code(save_move[i], 4);
      SHAPE_REVERSE: for (int i = eff - 1; i >= int'(sret); i--) add_code(save_move[i], 4);
      SHAPE_PUSHES: for (int i = sret; i < eff; i++) add_push(i);
      SHAPE_MIXED: begin
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(1)) add_code(save_move[$urandom_range(0, TABLE_LEN - 1)], 4);
          else add_push($urandom_range(0, TABLE_LEN - 1));
        end
      end
      default: repeat ($urandom_range(1, 16)) prolog_bytes.push_back(8'($urandom));
    endcase
    if ($urandom_range(99) < 15 && prolog_bytes.size() > 0)
      prolog_bytes[$urandom_range(0, prolog_bytes.size() - 1)] = 8'($urandom);
    repeat ($urandom_range(0, 4)) prolog_bytes.push_back(8'($urandom));
    if (prolog_bytes.size() == 0) prolog_bytes.push_back(8'($urandom));
  endtask

  task automatic pad_prologue(int len);
    while (prolog_bytes.size() < len) prolog_bytes.push_back(8'($urandom));
  endtask

  task automatic test_edge_cases();
    // bytes after reset with no first byte: count stays zero
    prolog_bytes = '{PUSH_RBP, 8'h48, 8'h89};
    send_prologue(8'd3, 1'b0, START_MISSING);
    // one-byte prologue
    prolog_bytes = '{PUSH_RBP};
    send_prologue(8'd3, 1'b0, START_MARKED);
    // zero count with a good frame and save
    prolog_bytes = '{PUSH_RBP, 8'h48, 8'h89, 8'he5, 8'h48, 8'h89, 8'h7d, 8'hf8};
    send_prologue(8'd0, 1'b0, START_MARKED);
    // short prologue, pushes only, final byte a push code
    prolog_bytes = '{PUSH_ALT, 8'h48, 8'h8b, 8'hec, 8'h56, 8'h52, 8'h51};
    send_prologue(8'hff, 1'b1, START_MARKED);
    // no frame pointer at all
    prolog_bytes = '{8'hff, 8'h00};
    send_prologue(8'd1, 1'b0, START_MARKED);
    // struct return with forward saves from rdi
    prolog_bytes = '{PUSH_RBP, 8'h48, 8'h89, 8'he5};
    add_code(save_move[0], 4);
    send_prologue(8'd0, 1'b1, START_MARKED);
  endtask

  task automatic test_random_prologues(int words, int send_pct, int recv_pct);
    int sent, r;
    logic [7:0] argc;
    bit sret;
    start_e start;
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
    sent = 0;
    while (sent < words) begin
      argc = pick_arg_count();
      sret = 1'($urandom_range(1));
      r = $urandom_range(0, 9);
      build_prologue(r < 3 ? SHAPE_FORWARD : r < 5 ? SHAPE_REVERSE : r < 8 ? SHAPE_PUSHES :
                     r < 9 ? SHAPE_MIXED : SHAPE_NOISE, eff_count(argc, sret), sret);
      if ($urandom_range(99) < 2) pad_prologue($urandom_range(60, 80));
      r = $urandom_range(99);
      start = (r < 5) ? START_MISSING : (r < 9) ? START_REPEATED : START_MARKED;
      send_prologue(argc, sret, start);
      sent += prolog_bytes.size();
    end
  endtask

  task automatic test_long_prologues();
    send_idle_pct <= 18;
    recv_stall_pct <= 18;
    build_prologue(SHAPE_FORWARD, 6, 1'b0);
    pad_prologue(80);
    send_prologue(8'd6, 1'b0, START_MARKED);
    // pushes straddle the byte limit
    build_prologue(SHAPE_PUSHES, 5, 1'b1);
    repeat (56) prolog_bytes.insert(4, 8'($urandom));
    send_prologue(8'd4, 1'b1, START_MARKED);
    // long enough for the position to saturate
    build_prologue(SHAPE_REVERSE, 5, 1'b0);
    pad_prologue(270);
    send_prologue(8'd5, 1'b0, START_MARKED);
  endtask

  // receiver holds off while the sender keeps offering short prologues
  task automatic test_output_holdoff();
    logic [7:0] argc;
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    hold_req <= !hold_req;
    repeat (10) begin
      argc = pick_arg_count();
      build_prologue(SHAPE_NOISE, eff_count(argc, 1'b0), 1'b0);
      prolog_bytes = prolog_bytes[0:(prolog_bytes.size() > 3 ? 2 : prolog_bytes.size() - 1)];
      send_prologue(argc, 1'b0, START_MARKED);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_cases();
    test_random_prologues(420, 0, 0);
    test_random_prologues(330, 56, 0);
    test_random_prologues(330, 0, 56);
    test_random_prologues(330, 18, 18);
    test_long_prologues();
    test_output_holdoff();
    in_tvalid <= 1'b0;
    while (kind_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
